// File: src/convolution_3x3_normalized_core_assert.svh
// assertion macros for the 3x3 normalized convolution core
`ifndef CONVOLUTION_3X3_NORMALIZED_CORE_ASSERT_SVH
`define CONVOLUTION_3X3_NORMALIZED_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CV3N_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cv3n assertion failed");
// next-cycle implication
`define CV3N_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cv3n assertion failed");
`else
`define CV3N_ASSERT_NOW(label, ante, cons)
`define CV3N_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: src/cv3n_pkg.sv
// shared types and constants of the 3x3 normalized convolution core
package cv3n_pkg;
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int PIXEL_BITS_DEF = 16;
   localparam int PORT_PIX_BITS  = 16;
   localparam int COEF_BITS      = 16;
   localparam int NUM_COEFS      = 9;
   localparam int CSUM_BITS      = COEF_BITS + 4;
   localparam int WIDTH_BITS     = 11;
   localparam int HEIGHT_BITS    = 13;
   localparam int ROW_BITS       = 12;
   localparam int GEOM_BITS      = 14;
   localparam int MAX_HEIGHT     = 4096;
   localparam int MIN_SIZE       = 3;
   localparam int QUEUE_DEPTH    = 2;
   localparam int CSR_DATA_BITS  = 64;
   localparam int CSR_ADDR_BITS  = 6;
   localparam int REG_IDX_BITS   = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_COEFS_LOW = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_COEFS_MID = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_COEF_LAST = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_WIDTH     = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_HEIGHT    = 3'd4;

   localparam logic [63:0] RST_COEFS_LOW = 64'd562954248519681;
   localparam logic [63:0] RST_COEFS_MID = 64'd562954248519684;
   localparam logic [COEF_BITS-1:0]   RST_COEF_LAST = 16'd1;
   localparam logic [WIDTH_BITS-1:0]  RST_WIDTH     = 11'd1024;
   localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT    = 13'd768;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef enum logic [1:0] {
      FS_CLEAR,
      FS_IDLE,
      FS_UPDATE
   } front_state_type;

   typedef enum logic [2:0] {
      BS_IDLE,
      BS_MAC,
      BS_SETUP,
      BS_DIV,
      BS_DONE
   } back_state_type;
endpackage

// File: src/cv3n_ram.sv
// generic single-write, single-read ram with registered read
module cv3n_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// File: src/cv3n_front.sv
// front end: pixel intake, line stores, 3x3 window and raster position
module cv3n_front #(
   parameter int MAX_WIDTH  = cv3n_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = cv3n_pkg::PIXEL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [cv3n_pkg::WIDTH_BITS-1:0]       cfg_width,
   input  logic [cv3n_pkg::HEIGHT_BITS-1:0]      cfg_height,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [cv3n_pkg::PORT_PIX_BITS-1:0]    req_pixel_in,
   input  cv3n_pkg::qstat_type                   q_stat,
   output logic                                  q_push,
   output logic [cv3n_pkg::NUM_COEFS*PIXEL_BITS:0] q_data
);
   localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int GB = cv3n_pkg::GEOM_BITS;
   localparam int HB = cv3n_pkg::HEIGHT_BITS;
   localparam int PB = PIXEL_BITS;

   cv3n_pkg::front_state_type state_ff, state_in;

   logic [AW-1:0]                     clr_ff, clr_in;
   logic [AW-1:0]                     col_ff, col_in;
   logic [cv3n_pkg::ROW_BITS-1:0]     row_ff, row_in;
   logic [PB-1:0]                     pix_ff, pix_in;
   logic [PB-1:0]                     win_ff [6];
   logic [PB-1:0]                     upper_rd, middle_rd;
   logic                              ram_we;
   logic [AW-1:0]                     ram_waddr;
   logic [PB-1:0]                     upper_wd, middle_wd;
   logic [GB-1:0]                     w_raw, w_eff;
   logic [HB-1:0]                     h_eff;
   logic                              last_col, last_row, interior;
   logic                              accept, clr_done;

   cv3n_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_upper (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(upper_wd),
      .raddr(col_ff), .rdata(upper_rd)
   );

   cv3n_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_middle (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(middle_wd),
      .raddr(col_ff), .rdata(middle_rd)
   );

   // clamped geometry
   always_comb begin
      w_raw = GB'(cfg_width);
      if (w_raw < GB'(cv3n_pkg::MIN_SIZE)) begin
         w_eff = GB'(cv3n_pkg::MIN_SIZE);
      end else if (w_raw > GB'(MAX_WIDTH)) begin
         w_eff = GB'(MAX_WIDTH);
      end else begin
         w_eff = w_raw;
      end
      if (cfg_height < HB'(cv3n_pkg::MIN_SIZE)) begin
         h_eff = HB'(cv3n_pkg::MIN_SIZE);
      end else if (cfg_height > HB'(cv3n_pkg::MAX_HEIGHT)) begin
         h_eff = HB'(cv3n_pkg::MAX_HEIGHT);
      end else begin
         h_eff = cfg_height;
      end
      last_col = (GB'(col_ff) + GB'(1)) >= w_eff;
      last_row = (HB'(row_ff) + HB'(1)) >= h_eff;
      interior = (row_ff >= cv3n_pkg::ROW_BITS'(2)) && (col_ff >= AW'(2));
   end

   assign clr_done = (clr_ff == AW'(MAX_WIDTH - 1));
   assign accept   = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cv3n_pkg::FS_CLEAR:  if (clr_done) state_in = cv3n_pkg::FS_IDLE;
         cv3n_pkg::FS_IDLE:   if (accept) state_in = cv3n_pkg::FS_UPDATE;
         cv3n_pkg::FS_UPDATE: state_in = cv3n_pkg::FS_IDLE;
         default:             state_in = cv3n_pkg::FS_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = !((state_ff == cv3n_pkg::FS_IDLE) && !q_stat.full);
      ram_we    = (state_ff == cv3n_pkg::FS_CLEAR) || (state_ff == cv3n_pkg::FS_UPDATE);
      ram_waddr = (state_ff == cv3n_pkg::FS_CLEAR) ? clr_ff : col_ff;
      upper_wd  = (state_ff == cv3n_pkg::FS_CLEAR) ? '0 : middle_rd;
      middle_wd = (state_ff == cv3n_pkg::FS_CLEAR) ? '0 : pix_ff;
      q_push    = (state_ff == cv3n_pkg::FS_UPDATE) && interior;
   end

   // neighborhood: k = 3*column + row
   always_comb begin
      for (int k = 0; k < 6; k++) begin
         q_data[k*PB +: PB] = win_ff[k];
      end
      q_data[6*PB +: PB] = upper_rd;
      q_data[7*PB +: PB] = middle_rd;
      q_data[8*PB +: PB] = pix_ff;
      q_data[cv3n_pkg::NUM_COEFS*PB] = last_col && last_row;
   end

   always_comb begin
      clr_in = clr_ff;
      col_in = col_ff;
      row_in = row_ff;
      pix_in = pix_ff;
      if (state_ff == cv3n_pkg::FS_CLEAR) begin
         clr_in = clr_ff + AW'(1);
      end
      if (accept) begin
         pix_in = req_pixel_in[PB-1:0];
      end
      if (state_ff == cv3n_pkg::FS_UPDATE) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + cv3n_pkg::ROW_BITS'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cv3n_pkg::FS_CLEAR;
         clr_ff   <= '0;
         col_ff   <= '0;
         row_ff   <= '0;
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (state_ff == cv3n_pkg::FS_UPDATE) begin
            win_ff[0] <= win_ff[3];
            win_ff[1] <= win_ff[4];
            win_ff[2] <= win_ff[5];
            win_ff[3] <= upper_rd;
            win_ff[4] <= middle_rd;
            win_ff[5] <= pix_ff;
         end
      end
      pix_ff <= pix_in;
   end
endmodule

// File: src/cv3n_queue.sv
// short fifo between front and back end
module cv3n_queue #(
   parameter int WIDTH = 145,
   parameter int DEPTH = cv3n_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  logic [WIDTH-1:0]    push_data,
   input  logic                pop,
   output logic [WIDTH-1:0]    head_data,
   output cv3n_pkg::qstat_type stat
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + PW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + PW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CW'(1);
      end
      stat.full  = (cnt_ff == CW'(DEPTH));
      stat.empty = (cnt_ff == '0);
      head_data  = slot_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule

// File: src/cv3n_back.sv
// back end: serial multiply-accumulate, serial divide, saturation, result register
module cv3n_back #(
   parameter int PIXEL_BITS = cv3n_pkg::PIXEL_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic [cv3n_pkg::NUM_COEFS*cv3n_pkg::COEF_BITS-1:0] coefs,
   input  cv3n_pkg::qstat_type                              q_stat,
   input  logic [cv3n_pkg::NUM_COEFS*PIXEL_BITS:0]          q_data,
   output logic                                             q_pop,
   output logic                                             rsp_valid,
   input  logic                                             rsp_stall,
   output logic [cv3n_pkg::PORT_PIX_BITS-1:0]               rsp_pixel_out,
   output logic                                             rsp_end_of_frame,
   output logic                                             rsp_zero_sum_error
);
   localparam int PB  = PIXEL_BITS;
   localparam int CB  = cv3n_pkg::COEF_BITS;
   localparam int SB  = cv3n_pkg::CSUM_BITS;
   localparam int NC  = cv3n_pkg::NUM_COEFS;
   localparam int PRB = CB + PB + 1;
   localparam int AB  = PRB + 4;
   localparam int EW  = NC * PB + 1;
   localparam int KB  = $clog2(NC);
   localparam int DB  = $clog2(AB);
   localparam logic [AB-1:0] PIX_MAX = AB'((64'd1 << PB) - 64'd1);

   cv3n_pkg::back_state_type state_ff, state_in;

   logic [EW-1:0]        ent_ff;
   logic [KB-1:0]        k_ff;
   logic signed [AB-1:0] acc_ff;
   logic signed [SB-1:0] csum_ff;
   logic [AB-1:0]        dvd_ff;
   logic [SB-1:0]        dvs_ff;
   logic [SB:0]          rem_ff;
   logic [DB-1:0]        cnt_ff;
   logic                 zero_ff, err_ff;
   logic                 out_valid_ff;
   logic [PB-1:0]        out_pix_ff;
   logic                 out_eof_ff, out_err_ff;

   logic signed [CB-1:0]  coef_k;
   logic [PB-1:0]         pix_k;
   logic signed [PRB-1:0] product;
   logic [SB:0]           rem_shift;
   logic                  fits;
   logic                  load_out;
   logic [AB-1:0]         quot;
   logic [PB-1:0]         sat_pix;

   always_comb begin
      coef_k    = $signed(coefs[k_ff*CB +: CB]);
      pix_k     = ent_ff[k_ff*PB +: PB];
      product   = coef_k * $signed({1'b0, pix_k});
      rem_shift = {rem_ff[SB-1:0], dvd_ff[AB-1]};
      fits      = rem_shift >= {1'b0, dvs_ff};
      quot      = zero_ff ? '0 : dvd_ff;
      sat_pix   = (quot > PIX_MAX) ? PIX_MAX[PB-1:0] : quot[PB-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cv3n_pkg::BS_IDLE:  if (!q_stat.empty) state_in = cv3n_pkg::BS_MAC;
         cv3n_pkg::BS_MAC:   if (k_ff == KB'(NC - 1)) state_in = cv3n_pkg::BS_SETUP;
         cv3n_pkg::BS_SETUP: begin
            if ((csum_ff == '0) || (acc_ff[AB-1] != csum_ff[SB-1])) begin
               state_in = cv3n_pkg::BS_DONE;
            end else begin
               state_in = cv3n_pkg::BS_DIV;
            end
         end
         cv3n_pkg::BS_DIV:   if (cnt_ff == DB'(AB - 1)) state_in = cv3n_pkg::BS_DONE;
         cv3n_pkg::BS_DONE:  if (!out_valid_ff || !rsp_stall) state_in = cv3n_pkg::BS_IDLE;
         default:            state_in = cv3n_pkg::BS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop    = (state_ff == cv3n_pkg::BS_IDLE) && !q_stat.empty;
      load_out = (state_ff == cv3n_pkg::BS_DONE) && (!out_valid_ff || !rsp_stall);
      rsp_valid          = out_valid_ff;
      rsp_pixel_out      = cv3n_pkg::PORT_PIX_BITS'(out_pix_ff);
      rsp_end_of_frame   = out_eof_ff;
      rsp_zero_sum_error = out_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cv3n_pkg::BS_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
      unique case (state_ff)
         cv3n_pkg::BS_IDLE: begin
            ent_ff  <= q_data;
            k_ff    <= '0;
            acc_ff  <= '0;
            csum_ff <= '0;
         end
         cv3n_pkg::BS_MAC: begin
            acc_ff  <= acc_ff + AB'(product);
            csum_ff <= csum_ff + SB'(coef_k);
            k_ff    <= k_ff + KB'(1);
         end
         cv3n_pkg::BS_SETUP: begin
            err_ff  <= (csum_ff == '0);
            zero_ff <= (csum_ff == '0) || (acc_ff[AB-1] != csum_ff[SB-1]);
            dvd_ff  <= acc_ff[AB-1] ? AB'(-acc_ff) : AB'(acc_ff);
            dvs_ff  <= csum_ff[SB-1] ? SB'(-csum_ff) : SB'(csum_ff);
            rem_ff  <= '0;
            cnt_ff  <= '0;
         end
         cv3n_pkg::BS_DIV: begin
            rem_ff <= fits ? (rem_shift - {1'b0, dvs_ff}) : rem_shift;
            dvd_ff <= {dvd_ff[AB-2:0], fits};
            cnt_ff <= cnt_ff + DB'(1);
         end
         default: begin
         end
      endcase
      if (load_out) begin
         out_pix_ff <= sat_pix;
         out_eof_ff <= ent_ff[EW-1];
         out_err_ff <= err_ff;
      end
   end
endmodule

// File: src/convolution_3x3_normalized_core.sv
// top level of the 3x3 convolution core normalized by the kernel sum
// Streams a greyscale frame in raster order, one request per pixel, and
// returns one filtered pixel for every interior position (the output frame is
// two pixels narrower and two rows shorter). Each result is the 3x3 weighted
// sum divided by the coefficient sum, truncated toward zero and saturated to
// 0..2^PIXEL_BITS-1; a zero coefficient sum yields 0 with zero_sum_error set.
// Flow: the front end reads the line stores as it accepts a pixel, then
// writes them back in its update state; it takes no new pixel before that
// write-back or while the queue is full. Border pixels need only this.
// Interior pixels go through a 2-entry queue to the back end, which takes
// the entry from the queue, runs the serial multiply-accumulate over the
// nine coefficients, a setup step and the bit-serial divider, then loads the
// result register once it is free, and only then takes the next entry.
// Results with a negative quotient or a zero sum skip the divider. After
// reset req_stall is high while the line stores are cleared; register writes
// are taken at any time. Registers sit at 8-byte steps: coefficients 0-3,
// coefficients 4-7, coefficient 8, width, height.
module convolution_3x3_normalized_core #(
   parameter int MAX_WIDTH  = cv3n_pkg::MAX_WIDTH_DEF,
   parameter int PIXEL_BITS = cv3n_pkg::PIXEL_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // pixel requests
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [cv3n_pkg::PORT_PIX_BITS-1:0]    req_pixel_in,
   // filtered results
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cv3n_pkg::PORT_PIX_BITS-1:0]    rsp_pixel_out,
   output logic                                  rsp_end_of_frame,
   output logic                                  rsp_zero_sum_error,
   // register port
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [cv3n_pkg::CSR_ADDR_BITS-1:0]    paddr,
   input  logic [cv3n_pkg::CSR_DATA_BITS-1:0]    pwdata,
   output logic [cv3n_pkg::CSR_DATA_BITS-1:0]    prdata,
   output logic                                  pready
);
`include "convolution_3x3_normalized_core_assert.svh"

   localparam int QW = cv3n_pkg::NUM_COEFS * PIXEL_BITS + 1;
   localparam int CB = cv3n_pkg::COEF_BITS;
   localparam int DW = cv3n_pkg::CSR_DATA_BITS;

   // configuration registers
   logic [DW-1:0]                       coefs_low_ff;
   logic [DW-1:0]                       coefs_mid_ff;
   logic [CB-1:0]                       coef_last_ff;
   logic [cv3n_pkg::WIDTH_BITS-1:0]     width_ff;
   logic [cv3n_pkg::HEIGHT_BITS-1:0]    height_ff;
   logic [cv3n_pkg::REG_IDX_BITS-1:0]   reg_idx;
   logic                                csr_write;

   // front/back plumbing
   cv3n_pkg::qstat_type                 q_stat;
   logic                                q_push, q_pop;
   logic [QW-1:0]                       q_in, q_head;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[cv3n_pkg::CSR_ADDR_BITS-1:3];
   assign csr_write = psel && penable && pwrite && pready;

   // register readback, zero-extended
   always_comb begin
      unique case (reg_idx)
         cv3n_pkg::REG_COEFS_LOW: prdata = coefs_low_ff;
         cv3n_pkg::REG_COEFS_MID: prdata = coefs_mid_ff;
         cv3n_pkg::REG_COEF_LAST: prdata = DW'(coef_last_ff);
         cv3n_pkg::REG_WIDTH:     prdata = DW'(width_ff);
         cv3n_pkg::REG_HEIGHT:    prdata = DW'(height_ff);
         default:                 prdata = '0;
      endcase
   end

   // register writes; addresses beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         coefs_low_ff <= cv3n_pkg::RST_COEFS_LOW;
         coefs_mid_ff <= cv3n_pkg::RST_COEFS_MID;
         coef_last_ff <= cv3n_pkg::RST_COEF_LAST;
         width_ff     <= cv3n_pkg::RST_WIDTH;
         height_ff    <= cv3n_pkg::RST_HEIGHT;
      end else if (csr_write) begin
         unique case (reg_idx)
            cv3n_pkg::REG_COEFS_LOW: coefs_low_ff <= pwdata;
            cv3n_pkg::REG_COEFS_MID: coefs_mid_ff <= pwdata;
            cv3n_pkg::REG_COEF_LAST: coef_last_ff <= pwdata[CB-1:0];
            cv3n_pkg::REG_WIDTH:     width_ff <= pwdata[cv3n_pkg::WIDTH_BITS-1:0];
            cv3n_pkg::REG_HEIGHT:    height_ff <= pwdata[cv3n_pkg::HEIGHT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // front end: raster position, line stores and window
   cv3n_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg_width    (width_ff),
      .cfg_height   (height_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_pixel_in (req_pixel_in),
      .q_stat       (q_stat),
      .q_push       (q_push),
      .q_data       (q_in)
   );

   // neighborhoods of interior pixels waiting for the arithmetic
   cv3n_queue #(.WIDTH(QW), .DEPTH(cv3n_pkg::QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head_data (q_head),
      .stat      (q_stat)
   );

   // back end: weighted sum, division, saturation, result register
   cv3n_back #(.PIXEL_BITS(PIXEL_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .coefs              ({coef_last_ff, coefs_mid_ff, coefs_low_ff}),
      .q_stat             (q_stat),
      .q_data             (q_head),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pixel_out      (rsp_pixel_out),
      .rsp_end_of_frame   (rsp_end_of_frame),
      .rsp_zero_sum_error (rsp_zero_sum_error)
   );

   // line-store clearing holds off requests right after reset
   `CV3N_ASSERT_NOW(a_clear_stalls, $past(reset), req_stall)
   // the front end never pushes into a full queue
   `CV3N_ASSERT_NOW(a_no_overflow, q_push, !q_stat.full)
   // the back end never pops an empty queue
   `CV3N_ASSERT_NOW(a_no_underflow, q_pop, !q_stat.empty)
   // a zero kernel sum always delivers a black pixel
   `CV3N_ASSERT_NOW(a_zero_sum_black, rsp_valid && rsp_zero_sum_error, rsp_pixel_out == '0)
endmodule

// File: tb/sv/convolution_3x3_normalized_core_checker.sv
// checker for the 3x3 normalized convolution core: kernel predictor and result compare
module convolution_3x3_normalized_core_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [cv3n_pkg::PORT_PIX_BITS-1:0]  req_pixel_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [cv3n_pkg::PORT_PIX_BITS-1:0]  rsp_pixel_out,
   input  logic                                rsp_end_of_frame,
   input  logic                                rsp_zero_sum_error,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic                                pready,
   input  logic [cv3n_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [cv3n_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output int                                  fail_count,
   output int                                  pending,
   output int                                  result_count,
   output int                                  zero_sum_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import cv3n_pkg::*;

   localparam int LINE_LEN = MAX_WIDTH_DEF;
   localparam longint PIX_TOP = (64'd1 << PIXEL_BITS_DEF) - 1;

   typedef struct {
      logic [15:0] pixel;
      logic        eof;
      logic        zero_sum;
   } filtered_pixel_type;

   logic [63:0] kern_lo, kern_mid;
   logic [15:0] kern_last;
   logic [10:0] width_reg;
   logic [12:0] height_reg;
   logic [15:0] row_above [LINE_LEN];
   logic [15:0] row_mid [LINE_LEN];
   logic [15:0] window [6];
   int unsigned col_pos, row_pos;
   filtered_pixel_type filtered_q [$];

   function automatic longint kernel_coef(input int k);
      if (k < 4) return longint'($signed(kern_lo[16*k +: 16]));
      if (k < 8) return longint'($signed(kern_mid[16*(k-4) +: 16]));
      return longint'($signed(kern_last));
   endfunction

   task automatic clear_filter();
      kern_lo = RST_COEFS_LOW;
      kern_mid = RST_COEFS_MID;
      kern_last = RST_COEF_LAST;
      width_reg = RST_WIDTH;
      height_reg = RST_HEIGHT;
      for (int i = 0; i < LINE_LEN; i++) begin
         row_above[i] = '0;
         row_mid[i] = '0;
      end
      for (int i = 0; i < 6; i++) window[i] = '0;
      col_pos = 0;
      row_pos = 0;
      filtered_q.delete();
   endtask

   // advance the window by one pixel, queue a filtered pixel when interior
   task automatic take_pixel(input logic [15:0] p);
      int unsigned w, h, addr;
      logic [15:0] col_now [3];
      logic [15:0] nb [9];
      longint acc, csum, quot;
      bit last_col, last_row;
      filtered_pixel_type fp;
      w = width_reg;
      if (w < MIN_SIZE) w = MIN_SIZE;
      if (w > LINE_LEN) w = LINE_LEN;
      h = height_reg;
      if (h < MIN_SIZE) h = MIN_SIZE;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      addr = (col_pos < LINE_LEN) ? col_pos : LINE_LEN - 1;
      last_col = (col_pos + 1 >= w);
      last_row = (row_pos + 1 >= h);
      col_now[0] = row_above[addr];
      col_now[1] = row_mid[addr];
      col_now[2] = p;
      for (int k = 0; k < 3; k++) begin
         nb[k] = window[k];
         nb[3+k] = window[3+k];
         nb[6+k] = col_now[k];
      end
      if (row_pos >= 2 && col_pos >= 2) begin
         acc = 0;
         csum = 0;
         for (int k = 0; k < 9; k++) begin
            acc += kernel_coef(k) * longint'({48'd0, nb[k]});
            csum += kernel_coef(k);
         end
         if (csum == 0) begin
            quot = 0;
         end else begin
            quot = acc / csum;
            if (quot < 0) quot = 0;
            if (quot > PIX_TOP) quot = PIX_TOP;
         end
         fp.pixel = quot[15:0];
         fp.eof = last_col && last_row;
         fp.zero_sum = (csum == 0);
         filtered_q.push_back(fp);
      end
      row_above[addr] = col_now[1];
      row_mid[addr] = p;
      for (int k = 0; k < 3; k++) begin
         window[k] = window[3+k];
         window[3+k] = col_now[k];
      end
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((row_pos + 1) & 12'hFFF);
      end else begin
         col_pos = (col_pos + 1) & 10'h3FF;
      end
   endtask

   always @(posedge clock) begin
      filtered_pixel_type want;
      if (reset) begin
         clear_filter();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2:0] == 3'b000) begin
            case (paddr[5:3])
               REG_COEFS_LOW: kern_lo = pwdata;
               REG_COEFS_MID: kern_mid = pwdata;
               REG_COEF_LAST: kern_last = pwdata[15:0];
               REG_WIDTH:     width_reg = pwdata[10:0];
               REG_HEIGHT:    height_reg = pwdata[12:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) take_pixel(req_pixel_in);
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (rsp_zero_sum_error) zero_sum_count <= zero_sum_count + 1;
            if (filtered_q.size() == 0) begin
               if (fail_count < 10)
                  $display("[%0t] unexpected result pixel=%h eof=%b err=%b", $realtime,
                     rsp_pixel_out, rsp_end_of_frame, rsp_zero_sum_error);
               fail_count <= fail_count + 1;
            end else begin
               want = filtered_q.pop_front();
               if (want.pixel !== rsp_pixel_out || want.eof !== rsp_end_of_frame ||
                     want.zero_sum !== rsp_zero_sum_error) begin
                  if (fail_count < 10)
                     $display("[%0t] mismatch: expected pixel=%h eof=%b err=%b, got %h %b %b",
                        $realtime, want.pixel, want.eof, want.zero_sum,
                        rsp_pixel_out, rsp_end_of_frame, rsp_zero_sum_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending <= filtered_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
      result_count = 0;
      zero_sum_count = 0;
   end
endmodule

// File: tb/sv/convolution_3x3_normalized_core_tb.sv
// testbench top for the 3x3 normalized convolution core: stimulus and verdict
module convolution_3x3_normalized_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cv3n_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE_CYCLES = 64;   // longer than one trip through the divider back end
   localparam int PHASE_PIXELS = 160;

   logic clock;
   logic reset;
   logic req_valid, req_stall;
   logic [PORT_PIX_BITS-1:0] req_pixel_in;
   logic rsp_valid, rsp_stall;
   logic [PORT_PIX_BITS-1:0] rsp_pixel_out;
   logic rsp_end_of_frame, rsp_zero_sum_error;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata, prdata;

   int fail_count, pending, result_count, zero_sum_count;
   int sender_idle_pct, receiver_stall_pct;
   int cycle_count;
   int pixels_sent;

   convolution_3x3_normalized_core dut (.*);

   convolution_3x3_normalized_core_checker checker_i (
      .clock, .reset, .req_valid, .req_stall, .req_pixel_in,
      .rsp_valid, .rsp_stall, .rsp_pixel_out, .rsp_end_of_frame, .rsp_zero_sum_error,
      .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
      .fail_count, .pending, .result_count, .zero_sum_count
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver back-pressure, redrawn every cycle from the current phase setting
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // register write: setup cycle, then access cycle; pready is always high
   task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [63:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // load a whole kernel; the upper bits of the last coefficient word are junk
   task automatic load_kernel(input logic [15:0] c [9]);
      write_reg(REG_COEFS_LOW, {c[3], c[2], c[1], c[0]});
      write_reg(REG_COEFS_MID, {c[7], c[6], c[5], c[4]});
      write_reg(REG_COEF_LAST, {$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF_0000 | 64'(c[8]));
   endtask

   task automatic set_geometry(input int w, input int h);
      write_reg(REG_WIDTH, 64'(w));
      write_reg(REG_HEIGHT, 64'(h));
   endtask

   // one pixel request; returns at the clock edge that accepted it
   task automatic send_pixel(input logic [15:0] value);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= value;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // all results in, then let a border pixel's leftover work drain;
   // one edge first so the count includes the last accepted pixel
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] rand_pixel();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom());
      endcase
   endfunction

   logic [15:0] kern [9];
   int csum, w, h;

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_in = '0;
      rsp_stall = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      cycle_count = 0;
      pixels_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset gaussian on a 3x3 frame of bright/dark extremes
      set_geometry(3, 3);
      for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 16'hFFFF : 16'h0000);
      drain();

      // directed: zero coefficient sum, error flag and 0 expected
      kern = '{16'd1, 16'hFFFF, 16'd2, 16'hFFFE, 16'd0, 16'd5, 16'hFFFB, 16'd3, 16'hFFFD};
      load_kernel(kern);
      for (int i = 0; i < 9; i++) send_pixel(rand_pixel());
      drain();

      // directed: extreme coefficients, sum of one, so the quotient saturates high
      kern = '{16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h8000, 16'd2};
      load_kernel(kern);
      for (int i = 0; i < 9; i++) send_pixel(16'(16'hFFFF - i));
      drain();

      // random phases: kernel style, geometry and idling all vary phase to phase;
      // frames straddle phases so geometry also changes mid-frame
      for (int ph = 0; ph < 10; ph++) begin
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
            default: begin sender_idle_pct = 15; receiver_stall_pct = 15; end
         endcase
         csum = 0;
         for (int k = 0; k < 9; k++) begin
            case (ph % 3)
               0: kern[k] = 16'($urandom_range(0, 8));                  // smoothing
               1: kern[k] = 16'($urandom());                            // anything
               default: kern[k] = 16'($signed($urandom_range(0, 200)) - 100); // mixed signs
            endcase
            csum += $signed(kern[k]);
         end
         if (ph == 5 || ph == 8) kern[8] = 16'(-(csum - $signed(kern[8]))); // force a zero sum
         load_kernel(kern);
         case ($urandom_range(0, 9))
            0: w = $urandom_range(0, 2);        // clamps up to the minimum
            1: w = (ph == 7) ? 1024 : 2047;     // full line, or clamped down
            default: w = $urandom_range(3, 10);
         endcase
         case ($urandom_range(0, 9))
            0: h = $urandom_range(0, 2);
            1: h = 8191;
            default: h = $urandom_range(3, 7);
         endcase
         set_geometry(w, h);
         for (int i = 0; i < PHASE_PIXELS; i++) send_pixel(rand_pixel());
         drain();
      end

      $display("sent %0d pixel requests over 13 kernel and geometry settings", pixels_sent);
      $display("got %0d filtered pixels, %0d of them flagged zero kernel sum",
         result_count, zero_sum_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// File: sim.f
+incdir+src
src/cv3n_pkg.sv
src/cv3n_ram.sv
src/cv3n_front.sv
src/cv3n_queue.sv
src/cv3n_back.sv
src/convolution_3x3_normalized_core.sv
tb/sv/convolution_3x3_normalized_core_checker.sv
tb/sv/convolution_3x3_normalized_core_tb.sv
